// ===== sv/crc32fc_pkg.sv =====
// ----------------------------------------------------------------------------
// crc32fc_pkg
// Shared constants and the bytewise reflected CRC-32 update for the frame
// checker.
// ----------------------------------------------------------------------------
package crc32fc_pkg;

  localparam int PAYLOAD_BYTES = 4096;
  localparam int FRAME_BYTES   = PAYLOAD_BYTES + 4;
  localparam int POS_W         = $clog2(FRAME_BYTES);

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

  localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(PAYLOAD_BYTES);
  localparam logic [POS_W-1:0] POS_LAST    = POS_W'(PAYLOAD_BYTES + 3);

  typedef logic [31:0] crc_t;
  typedef logic [POS_W-1:0] pos_t;

  // one byte through the reflected crc, lsb first
  function automatic crc_t crc_byte(input crc_t crc, input logic [7:0] data);
    crc_t c;
    c = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== sv/crc32_frame_checker.sv =====
// ----------------------------------------------------------------------------
// crc32_frame_checker
// Frames received bytes by count, checks each frame's payload against its
// little-endian CRC-32 trailer and reports the result with running counts.
// ----------------------------------------------------------------------------
// the result is registered and valid in the cycle after the last trailer byte
// one byte per cycle; a pending result stalls only the last trailer byte of
//   the next frame
// a frame is PAYLOAD_BYTES + 4 bytes, tracked by the byte position counter
// reset: position and counters cleared, crc register all ones, no result
module crc32_frame_checker
  import crc32fc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        frame_ok,
  output logic [31:0] computed_crc,
  output logic [31:0] trailer_crc,
  output logic [31:0] frame_count,
  output logic [31:0] good_count,
  output logic [31:0] bad_count
);

  pos_t        byte_position;
  crc_t        running_crc;
  logic [31:0] trailer_shift;

  crc_t        crc_step_out;
  logic [31:0] trailer_next;
  crc_t        calc;
  logic        match;
  logic        in_fire;
  logic        at_payload;
  logic        at_last;
  logic        out_busy;

  crc32fc_crc_step u_crc_step (
    .crc_in  (running_crc),
    .data    (rx_byte),
    .crc_out (crc_step_out)
  );

  assign at_payload   = byte_position < POS_PAYLOAD;
  assign at_last      = byte_position == POS_LAST;
  assign out_busy     = out_valid && !out_ready;
  assign in_ready     = !(out_busy && at_last);
  assign in_fire      = in_valid && in_ready;
  assign trailer_next = {rx_byte, trailer_shift[31:8]};
  assign calc         = running_crc ^ CRC_ONES;
  assign match        = calc == trailer_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      running_crc   <= CRC_ONES;
      trailer_shift <= '0;
      frame_count   <= '0;
      good_count    <= '0;
      bad_count     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (in_fire && at_last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_fire) begin
        if (at_payload) begin
          running_crc   <= crc_step_out;
          byte_position <= byte_position + pos_t'(1);
        end else if (!at_last) begin
          trailer_shift <= trailer_next;
          byte_position <= byte_position + pos_t'(1);
        end else begin
          byte_position <= '0;
          running_crc   <= CRC_ONES;
          trailer_shift <= '0;
          frame_count   <= frame_count + 32'd1;
          good_count    <= good_count + {31'd0, match};
          bad_count     <= bad_count + {31'd0, !match};
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire && at_last) begin
      frame_ok     <= match;
      computed_crc <= calc;
      trailer_crc  <= trailer_next;
    end
  end

  a_counts_sum: assert property (@(posedge clk) disable iff (rst)
    frame_count == good_count + bad_count)
    else $error("frame count differs from good plus bad");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && at_last) |-> !in_ready)
    else $error("pending result could be overwritten");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (in_fire && at_last) |=> (out_valid && byte_position == '0 &&
                              running_crc == CRC_ONES))
    else $error("frame end did not restart framing");

  a_ok_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frame_ok == (computed_crc == trailer_crc)))
    else $error("match flag inconsistent with crcs");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= POS_LAST)
    else $error("byte position out of frame");

endmodule

// ===== sv/crc32fc_crc_step.sv =====
// ----------------------------------------------------------------------------
// crc32fc_crc_step
// XOR network that advances the running CRC-32 register by one byte.
// ----------------------------------------------------------------------------
module crc32fc_crc_step
  import crc32fc_pkg::*;
(
  input  crc_t       crc_in,
  input  logic [7:0] data,
  output crc_t       crc_out
);

  assign crc_out = crc_byte(crc_in, data);

endmodule
